/* design/sdpf_pkg.sv */
package sdpf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ID_BITS   = 16;

  localparam int POS_W    = 26;
  localparam int RAD_W    = 17;
  localparam int BOX_W    = 10;
  localparam int SHEAR_W  = 26;
  localparam int K_W      = 20;
  localparam int FORCE_W  = 24;
  localparam int MOM_W    = 26;
  localparam int OX_W     = POS_W + 2;      // neighbour x after shear
  localparam int DIFF_W   = POS_W + 3;      // raw separation
  localparam int SQ_W     = 2 * DIFF_W - 2; // |sep|^2
  localparam int RSUM_W   = RAD_W + 1;
  localparam int SEP_W    = RSUM_W + 1;     // separation inside contact range
  localparam int D2_W     = 2 * RSUM_W;
  localparam int ROOT_W   = RSUM_W;
  localparam int SQ_REM_W = ROOT_W + 1;
  localparam int F_W      = K_W + RSUM_W - FRAC_BITS;
  localparam int N_W      = F_W + RSUM_W;
  localparam int PROD_W   = FORCE_W + SEP_W;
  localparam int MQ_W     = PROD_W - FRAC_BITS;
  localparam int ADDR_W   = 4;

  localparam logic [1:0] SHIFT_PLUS  = 2'b01;
  localparam logic [1:0] SHIFT_MINUS = 2'b11;

  localparam logic [1:0] REG_BOX_WIDTH    = 2'd0;
  localparam logic [1:0] REG_BOX_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_SHEAR_OFFSET = 2'd2;
  localparam logic [1:0] REG_STIFFNESS    = 2'd3;

  typedef struct packed {
    logic [SQ_REM_W-1:0]     rem;
    logic [ROOT_W-1:0]       root;
    logic [D2_W-1:0]         rad;
    logic [RSUM_W-1:0]       rsum;
    logic signed [SEP_W-1:0] dx;
    logic signed [SEP_W-1:0] dy;
    logic                    contact;
    logic                    zero;
  } sq_stage_t;

  typedef struct packed {
    logic [RSUM_W-1:0]       remx;
    logic [F_W-1:0]          lowx;
    logic [F_W-1:0]          qx;
    logic [RSUM_W-1:0]       remy;
    logic [F_W-1:0]          lowy;
    logic [F_W-1:0]          qy;
    logic [ROOT_W-1:0]       d;
    logic                    negx;
    logic                    negy;
    logic signed [SEP_W-1:0] dy;
    logic                    contact;
    logic                    zero;
  } div_stage_t;

  // floor(x/3) for x < 2048
  function automatic logic [BOX_W-1:0] div3(input logic [BOX_W:0] x);
    logic [BOX_W+12:0] p;
    p = {12'b0, x} * 23'd2731;
    return p[BOX_W+12:13];
  endfunction

  // one root bit of the digit-by-digit square root
  function automatic sq_stage_t sq_step(input sq_stage_t s);
    sq_stage_t n;
    logic [SQ_REM_W+1:0] t;
    logic [SQ_REM_W+1:0] trial;
    logic ge;
    n = s;
    t = {s.rem, s.rad[D2_W-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    ge = t >= trial;
    n.rem = ge ? SQ_REM_W'(t - trial) : t[SQ_REM_W-1:0];
    n.root = {s.root[ROOT_W-2:0], ge};
    n.rad = {s.rad[D2_W-3:0], 2'b00};
    return n;
  endfunction

  // one quotient bit of both restoring dividers
  function automatic div_stage_t dv_step(input div_stage_t s);
    div_stage_t n;
    logic [RSUM_W:0] tx;
    logic [RSUM_W:0] ty;
    logic gx;
    logic gy;
    n = s;
    tx = {s.remx, s.lowx[F_W-1]};
    ty = {s.remy, s.lowy[F_W-1]};
    gx = tx >= {1'b0, s.d};
    gy = ty >= {1'b0, s.d};
    n.remx = gx ? RSUM_W'(tx - {1'b0, s.d}) : tx[RSUM_W-1:0];
    n.remy = gy ? RSUM_W'(ty - {1'b0, s.d}) : ty[RSUM_W-1:0];
    n.lowx = {s.lowx[F_W-2:0], 1'b0};
    n.lowy = {s.lowy[F_W-2:0], 1'b0};
    n.qx = {s.qx[F_W-2:0], gx};
    n.qy = {s.qy[F_W-2:0], gy};
    return n;
  endfunction

  function automatic logic signed [MOM_W-1:0] sat_mom(input logic signed [MQ_W-1:0] v);
    logic signed [MQ_W-1:0] hi;
    logic signed [MQ_W-1:0] lo;
    hi = MQ_W'({1'b0, {(MOM_W-1){1'b1}}});
    lo = -hi - MQ_W'(1);
    if (v > hi) begin
      return {1'b0, {(MOM_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(MOM_W-1){1'b0}}};
    end else begin
      return v[MOM_W-1:0];
    end
  endfunction

endpackage

/* design/sdpf_pair_if.sv */
interface sdpf_pair_if;
  logic                           valid;
  logic                           ready;
  logic [sdpf_pkg::POS_W-1:0]     self_pos_x;
  logic [sdpf_pkg::POS_W-1:0]     self_pos_y;
  logic [sdpf_pkg::RAD_W-1:0]     self_radius;
  logic [sdpf_pkg::ID_BITS-1:0]   self_ident;
  logic [sdpf_pkg::POS_W-1:0]     other_pos_x;
  logic [sdpf_pkg::POS_W-1:0]     other_pos_y;
  logic [sdpf_pkg::RAD_W-1:0]     other_radius;
  logic [sdpf_pkg::ID_BITS-1:0]   other_ident;
  logic signed [1:0]              shear_shift;

  modport source (output valid, self_pos_x, self_pos_y, self_radius, self_ident,
                  other_pos_x, other_pos_y, other_radius, other_ident, shear_shift,
                  input ready);
  modport sink (input valid, self_pos_x, self_pos_y, self_radius, self_ident,
                other_pos_x, other_pos_y, other_radius, other_ident, shear_shift,
                output ready);
endinterface

/* design/sdpf_force_if.sv */
interface sdpf_force_if;
  logic                                valid;
  logic                                ready;
  logic signed [sdpf_pkg::FORCE_W-1:0] force_x;
  logic signed [sdpf_pkg::FORCE_W-1:0] force_y;
  logic signed [sdpf_pkg::MOM_W-1:0]   moment;
  logic                                in_contact;

  modport source (output valid, force_x, force_y, moment, in_contact, input ready);
  modport sink (input valid, force_x, force_y, moment, in_contact, output ready);
endinterface

/* design/soft_disk_pair_force.sv */
// Harmonic soft-disk pair force in a sheared periodic 2-D box. One pair beat
// is taken per clock while the pipeline is not held. A beat passes through
// shear/periodic shift and squaring, the overlap test, the pipelined square
// root (one root bit per stage), the spring force, the two dividers that
// form fx = f*dx/d and fy = f*dy/d (one quotient bit per stage), and sign,
// moment and saturation. The whole pipeline advances together; it holds
// only while a finished result beat waits at the output, so a beat is never
// dropped or repeated. Registers (APB, byte address 4*i): 0 box_width,
// 1 box_height, 2 shear_offset (Q10.16), 3 stiffness (Q4.16). Write them
// only while the pipeline is empty. Equal ids or no overlap give all zeros;
// coincident centers give zero force with in_contact set.
module soft_disk_pair_force (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sdpf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  sdpf_pair_if.sink                   pairs,
  sdpf_force_if.source                forces
);

  localparam int FB = sdpf_pkg::FRAC_BITS;
  localparam int PW = sdpf_pkg::POS_W;
  localparam int SQN = sdpf_pkg::ROOT_W;
  localparam int DVN = sdpf_pkg::F_W;

  // ---------------- configuration registers ----------------
  logic [sdpf_pkg::BOX_W-1:0]   box_width;
  logic [sdpf_pkg::BOX_W-1:0]   box_height;
  logic [sdpf_pkg::SHEAR_W-1:0] shear_offset;
  logic [sdpf_pkg::K_W-1:0]     stiffness;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_width    <= sdpf_pkg::BOX_W'(400);
      box_height   <= sdpf_pkg::BOX_W'(400);
      shear_offset <= '0;
      stiffness    <= sdpf_pkg::K_W'(65536);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        sdpf_pkg::REG_BOX_WIDTH:    box_width    <= pwdata[sdpf_pkg::BOX_W-1:0];
        sdpf_pkg::REG_BOX_HEIGHT:   box_height   <= pwdata[sdpf_pkg::BOX_W-1:0];
        sdpf_pkg::REG_SHEAR_OFFSET: shear_offset <= pwdata[sdpf_pkg::SHEAR_W-1:0];
        sdpf_pkg::REG_STIFFNESS:    stiffness    <= pwdata[sdpf_pkg::K_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      sdpf_pkg::REG_BOX_WIDTH:    prdata = 32'(box_width);
      sdpf_pkg::REG_BOX_HEIGHT:   prdata = 32'(box_height);
      sdpf_pkg::REG_SHEAR_OFFSET: prdata = 32'(shear_offset);
      sdpf_pkg::REG_STIFFNESS:    prdata = 32'(stiffness);
      default:                    prdata = '0;
    endcase
  end

  // Box thresholds, refreshed every cycle from the registers. Integer parts
  // of 2*box/3 and box/3, then moved to Q.16.
  logic [PW-1:0] thr_x;
  logic [PW-1:0] thr_y_hi;
  logic [PW-1:0] thr_y_lo;
  logic [PW-1:0] len_x;
  logic [PW-1:0] len_y;

  always_ff @(posedge clk) begin
    thr_x    <= {sdpf_pkg::div3({box_width, 1'b0}), {FB{1'b0}}};
    thr_y_hi <= {sdpf_pkg::div3({box_height, 1'b0}), {FB{1'b0}}};
    thr_y_lo <= {sdpf_pkg::div3({1'b0, box_height}), {FB{1'b0}}};
    len_x    <= {box_width, {FB{1'b0}}};
    len_y    <= {box_height, {FB{1'b0}}};
  end

  // ---------------- global pipeline advance ----------------
  // Everything moves when the output beat is empty or being taken.
  logic out_valid;
  logic adv;
  logic in_acc;

  assign adv = !out_valid || forces.ready;
  assign pairs.ready = adv;
  assign in_acc = pairs.valid && adv;

  // ---------------- stage 1: register pair, apply shear ----------------
  logic                                  v1;
  logic [PW-1:0]                         s1_sx;
  logic [PW-1:0]                         s1_sy;
  logic signed [sdpf_pkg::OX_W-1:0]      s1_ox;
  logic [PW-1:0]                         s1_oy;
  logic [sdpf_pkg::RSUM_W-1:0]           s1_rsum;
  logic                                  s1_idm;
  logic signed [sdpf_pkg::OX_W-1:0]      ox_next;

  always_comb begin
    case (pairs.shear_shift)
      sdpf_pkg::SHIFT_PLUS:
        ox_next = {2'b00, pairs.other_pos_x} + {2'b00, shear_offset};
      sdpf_pkg::SHIFT_MINUS:
        ox_next = {2'b00, pairs.other_pos_x} - {2'b00, shear_offset};
      default:
        ox_next = {2'b00, pairs.other_pos_x};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= pairs.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sx   <= pairs.self_pos_x;
      s1_sy   <= pairs.self_pos_y;
      s1_ox   <= ox_next;
      s1_oy   <= pairs.other_pos_y;
      s1_rsum <= {1'b0, pairs.self_radius} + {1'b0, pairs.other_radius};
      s1_idm  <= pairs.self_ident == pairs.other_ident;
    end
  end

  // ---------------- stage 2: raw x separation, y wrap flags ----------------
  logic                                  v2;
  logic signed [sdpf_pkg::DIFF_W-1:0]    s2_diffx;
  logic [PW-1:0]                         s2_sy;
  logic [PW-1:0]                         s2_oy;
  logic                                  s2_ydn;
  logic                                  s2_yup;
  logic [sdpf_pkg::RSUM_W-1:0]           s2_rsum;
  logic                                  s2_idm;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_diffx <= $signed({3'b000, s1_sx}) - {s1_ox[sdpf_pkg::OX_W-1], s1_ox};
      s2_sy    <= s1_sy;
      s2_oy    <= s1_oy;
      s2_ydn   <= (s1_sy > thr_y_hi) && (s1_oy < thr_y_lo);
      s2_yup   <= (s1_sy < thr_y_lo) && (s1_oy > thr_y_hi);
      s2_rsum  <= s1_rsum;
      s2_idm   <= s1_idm;
    end
  end

  // ---------------- stage 3: periodic image ----------------
  logic                                  v3;
  logic signed [sdpf_pkg::DIFF_W-1:0]    s3_dx;
  logic signed [sdpf_pkg::DIFF_W-1:0]    s3_dy;
  logic [sdpf_pkg::RSUM_W-1:0]           s3_rsum;
  logic                                  s3_idm;
  logic signed [sdpf_pkg::DIFF_W-1:0]    tx_s;
  logic signed [sdpf_pkg::DIFF_W-1:0]    dx_next;
  logic signed [sdpf_pkg::DIFF_W-1:0]    dy_base;
  logic signed [sdpf_pkg::DIFF_W-1:0]    dy_next;

  always_comb begin
    tx_s = $signed({3'b000, thr_x});
    if (s2_diffx > tx_s) begin
      dx_next = s2_diffx - $signed({3'b000, len_x});
    end else if (s2_diffx < -tx_s) begin
      dx_next = s2_diffx + $signed({3'b000, len_x});
    end else begin
      dx_next = s2_diffx;
    end
    dy_base = $signed({3'b000, s2_sy}) - $signed({3'b000, s2_oy});
    if (s2_ydn) begin
      dy_next = dy_base - $signed({3'b000, len_y});
    end else if (s2_yup) begin
      dy_next = dy_base + $signed({3'b000, len_y});
    end else begin
      dy_next = dy_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_dx   <= dx_next;
      s3_dy   <= dy_next;
      s3_rsum <= s2_rsum;
      s3_idm  <= s2_idm;
    end
  end

  // ---------------- stage 4: squares ----------------
  logic                                  v4;
  logic [sdpf_pkg::SQ_W-1:0]             s4_sqx;
  logic [sdpf_pkg::SQ_W-1:0]             s4_sqy;
  logic [sdpf_pkg::D2_W-1:0]             s4_r2;
  logic signed [sdpf_pkg::SEP_W-1:0]     s4_dx;
  logic signed [sdpf_pkg::SEP_W-1:0]     s4_dy;
  logic [sdpf_pkg::RSUM_W-1:0]           s4_rsum;
  logic                                  s4_idm;
  logic signed [2*sdpf_pkg::DIFF_W-1:0]  px;
  logic signed [2*sdpf_pkg::DIFF_W-1:0]  py;

  assign px = s3_dx * s3_dx;
  assign py = s3_dy * s3_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  // Only the low separation bits are kept: in contact |dx|,|dy| <= rsum.
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_sqx  <= px[sdpf_pkg::SQ_W-1:0];
      s4_sqy  <= py[sdpf_pkg::SQ_W-1:0];
      s4_r2   <= s3_rsum * s3_rsum;
      s4_dx   <= s3_dx[sdpf_pkg::SEP_W-1:0];
      s4_dy   <= s3_dy[sdpf_pkg::SEP_W-1:0];
      s4_rsum <= s3_rsum;
      s4_idm  <= s3_idm;
    end
  end

  // ---------------- stage 5: overlap test, square root entry ----------------
  sdpf_pkg::sq_stage_t      sq_r [0:SQN];
  logic [SQN:0]             v_sq;
  logic [sdpf_pkg::SQ_W:0]  d2;

  assign d2 = {1'b0, s4_sqx} + {1'b0, s4_sqy};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_sq <= '0;
    end else if (adv) begin
      v_sq <= {v_sq[SQN-1:0], v4};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r[0].rem     <= '0;
      sq_r[0].root    <= '0;
      sq_r[0].rad     <= d2[sdpf_pkg::D2_W-1:0];
      sq_r[0].rsum    <= s4_rsum;
      sq_r[0].dx      <= s4_dx;
      sq_r[0].dy      <= s4_dy;
      sq_r[0].contact <= (d2 <= (sdpf_pkg::SQ_W+1)'(s4_r2)) && !s4_idm;
      sq_r[0].zero    <= d2 == '0;
    end
  end

  // one root bit per stage
  for (genvar i = 0; i < SQN; i++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[i+1] <= sdpf_pkg::sq_step(sq_r[i]);
      end
    end
  end

  // ---------------- spring force magnitude ----------------
  logic                                  v_f;
  logic [sdpf_pkg::F_W-1:0]              f_mag;
  logic [sdpf_pkg::ROOT_W-1:0]           f_d;
  logic signed [sdpf_pkg::SEP_W-1:0]     f_dx;
  logic signed [sdpf_pkg::SEP_W-1:0]     f_dy;
  logic                                  f_contact;
  logic                                  f_zero;
  logic [sdpf_pkg::K_W+sdpf_pkg::RSUM_W-1:0] kprod;

  assign kprod = stiffness * (sq_r[SQN].rsum - sq_r[SQN].root);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_f <= 1'b0;
    end else if (adv) begin
      v_f <= v_sq[SQN];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_mag     <= kprod[sdpf_pkg::K_W+sdpf_pkg::RSUM_W-1:FB];
      f_d       <= sq_r[SQN].root;
      f_dx      <= sq_r[SQN].dx;
      f_dy      <= sq_r[SQN].dy;
      f_contact <= sq_r[SQN].contact;
      f_zero    <= sq_r[SQN].zero;
    end
  end

  // ---------------- dividend f*|sep|, divider entry ----------------
  sdpf_pkg::div_stage_t          dv_r [0:DVN];
  logic [DVN:0]                  v_dv;
  logic [sdpf_pkg::RSUM_W-1:0]   magx;
  logic [sdpf_pkg::RSUM_W-1:0]   magy;
  logic [sdpf_pkg::N_W-1:0]      nx;
  logic [sdpf_pkg::N_W-1:0]      ny;

  assign magx = f_dx[sdpf_pkg::SEP_W-1] ? sdpf_pkg::RSUM_W'(-f_dx) : sdpf_pkg::RSUM_W'(f_dx);
  assign magy = f_dy[sdpf_pkg::SEP_W-1] ? sdpf_pkg::RSUM_W'(-f_dy) : sdpf_pkg::RSUM_W'(f_dy);
  assign nx = f_mag * magx;
  assign ny = f_mag * magy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_dv <= '0;
    end else if (adv) begin
      v_dv <= {v_dv[DVN-1:0], v_f};
    end
  end

  // |sep| <= d, so the quotient fits in F_W bits and the top of the
  // dividend is already below d.
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0].remx    <= nx[sdpf_pkg::N_W-1:sdpf_pkg::F_W];
      dv_r[0].lowx    <= nx[sdpf_pkg::F_W-1:0];
      dv_r[0].qx      <= '0;
      dv_r[0].remy    <= ny[sdpf_pkg::N_W-1:sdpf_pkg::F_W];
      dv_r[0].lowy    <= ny[sdpf_pkg::F_W-1:0];
      dv_r[0].qy      <= '0;
      dv_r[0].d       <= f_d;
      dv_r[0].negx    <= f_dx[sdpf_pkg::SEP_W-1];
      dv_r[0].negy    <= f_dy[sdpf_pkg::SEP_W-1];
      dv_r[0].dy      <= f_dy;
      dv_r[0].contact <= f_contact;
      dv_r[0].zero    <= f_zero;
    end
  end

  for (genvar j = 0; j < DVN; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[j+1] <= sdpf_pkg::dv_step(dv_r[j]);
      end
    end
  end

  // ---------------- sign and gating ----------------
  logic                                  v_o;
  logic signed [sdpf_pkg::FORCE_W-1:0]   o_fx;
  logic signed [sdpf_pkg::FORCE_W-1:0]   o_fy;
  logic signed [sdpf_pkg::SEP_W-1:0]     o_ndy;
  logic                                  o_contact;
  logic signed [sdpf_pkg::FORCE_W-1:0]   qx_s;
  logic signed [sdpf_pkg::FORCE_W-1:0]   qy_s;
  logic                                  live;

  assign qx_s = $signed({2'b00, dv_r[DVN].qx});
  assign qy_s = $signed({2'b00, dv_r[DVN].qy});
  assign live = dv_r[DVN].contact && !dv_r[DVN].zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_o <= 1'b0;
    end else if (adv) begin
      v_o <= v_dv[DVN];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_fx      <= !live ? '0 : (dv_r[DVN].negx ? -qx_s : qx_s);
      o_fy      <= !live ? '0 : (dv_r[DVN].negy ? -qy_s : qy_s);
      o_ndy     <= -dv_r[DVN].dy;
      o_contact <= dv_r[DVN].contact;
    end
  end

  // ---------------- moment product ----------------
  logic                                  v_m;
  logic signed [sdpf_pkg::PROD_W-1:0]    m_prod;
  logic signed [sdpf_pkg::FORCE_W-1:0]   m_fx;
  logic signed [sdpf_pkg::FORCE_W-1:0]   m_fy;
  logic                                  m_contact;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m <= 1'b0;
    end else if (adv) begin
      v_m <= v_o;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_prod    <= o_fx * o_ndy;
      m_fx      <= o_fx;
      m_fy      <= o_fy;
      m_contact <= o_contact;
    end
  end

  // ---------------- output beat ----------------
  // Scale back by 2^FRAC_BITS truncating toward zero, then saturate.
  logic signed [sdpf_pkg::PROD_W-1:0]    m_adj;
  logic signed [sdpf_pkg::FORCE_W-1:0]   r_fx;
  logic signed [sdpf_pkg::FORCE_W-1:0]   r_fy;
  logic signed [sdpf_pkg::MOM_W-1:0]     r_mom;
  logic                                  r_contact;

  assign m_adj = m_prod[sdpf_pkg::PROD_W-1]
               ? m_prod + $signed({{(sdpf_pkg::PROD_W-FB){1'b0}}, {FB{1'b1}}})
               : m_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v_m;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_fx      <= m_fx;
      r_fy      <= m_fy;
      r_mom     <= sdpf_pkg::sat_mom(m_adj[sdpf_pkg::PROD_W-1:FB]);
      r_contact <= m_contact;
    end
  end

  assign forces.valid      = out_valid;
  assign forces.force_x    = r_fx;
  assign forces.force_y    = r_fy;
  assign forces.moment     = r_mom;
  assign forces.in_contact = r_contact;

  // ---------------- assertions ----------------
  // No contact means an all-zero result beat.
  a_no_contact_zero: assert property (@(posedge clk) disable iff (rst)
    forces.valid && !forces.in_contact |->
      forces.force_x == '0 && forces.force_y == '0 && forces.moment == '0)
    else $error("force without contact");

  // In contact the distance never exceeds the radius sum.
  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    v_sq[SQN] && sq_r[SQN].contact |-> sq_r[SQN].root <= sq_r[SQN].rsum)
    else $error("square root above radius sum");

  // Moment is x force times separation: it needs a nonzero x force.
  a_moment_needs_fx: assert property (@(posedge clk) disable iff (rst)
    forces.valid && forces.moment != '0 |-> forces.force_x != '0)
    else $error("moment without x force");

  // A beat taken at the input is matched by pipeline occupancy next cycle.
  a_entry_tracked: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> v1)
    else $error("accepted beat lost at entry");

endmodule
